/* rtl/rspb_pkg.sv */
// shared types and constants for the rssi peak brightness controller
`default_nettype none
package rspb_pkg;
	localparam int HISTORY_DEPTH_DEF = 10;

	localparam int FUNC_W  = 2;
	localparam int RSSI_W  = 8;
	localparam int TIME_W  = 32;
	localparam int MV_W    = 13;
	localparam int DUTY_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int NUM_W   = 34;
	localparam int DEN_W   = 18;
	localparam int QUOT_W  = 16;
	localparam int RECIP_W = 17;

	localparam logic [FUNC_W-1:0] FUNC_PACKET = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_VOLT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MV  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MV  = 3'd4;

	localparam logic              RST_MAP_MODE   = 1'b1;
	localparam logic [15:0]       RST_TIMEOUT    = 16'd1000;
	localparam logic [DUTY_W-1:0] RST_FULL_SCALE = 16'd65535;
	localparam logic [MV_W-1:0]   RST_REDUCE_MV  = 13'd3500;
	localparam logic [MV_W-1:0]   RST_CUTOFF_MV  = 13'd3200;

	localparam logic signed [RSSI_W-1:0]  LVL_FLOOR    = -8'sd100;
	localparam logic signed [RSSI_W-1:0]  LVL_TOP      = -8'sd40;
	localparam logic signed [LEVEL_W-1:0] LVL_Q8_FLOOR = -16'sd25600;

	localparam logic [DUTY_W-1:0] DUTY_MIN = 16'd2;
	localparam logic [21:0]       FADE_NUM = 22'd51;
	localparam logic [21:0]       FADE_RND = 22'd255;
	localparam logic [DEN_W-1:0]  LIN_DEN  = 18'd60;
	localparam logic [NUM_W-1:0]  LIN_RND  = 34'd30;
	localparam logic [DEN_W-1:0]  CUBE_DEN = 18'd216000;
	localparam logic [NUM_W-1:0]  CUBE_RND = 34'd108000;

	// floor(2^shift / den) for each mapping divisor
	localparam logic [RECIP_W-1:0] LIN_RECIP  = 17'd69905;
	localparam int                 LIN_SHIFT  = 22;
	localparam logic [RECIP_W-1:0] CUBE_RECIP = 17'd79536;
	localparam int                 CUBE_SHIFT = 34;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PEAK,
		ST_UPD,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DSTART,
		ST_DWAIT,
		ST_FIN
	} state_t;
endpackage
`default_nettype wire

/* rtl/rspb_cell.sv */
// one history cell: holds an rssi entry and forwards the running peak
`default_nettype none
module rspb_cell (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 shift_en,
	input  wire logic signed [rspb_pkg::RSSI_W-1:0]   data_in,
	input  wire logic signed [rspb_pkg::RSSI_W-1:0]   max_in,
	output logic signed [rspb_pkg::RSSI_W-1:0]        data_out,
	output logic signed [rspb_pkg::RSSI_W-1:0]        max_out
);
	logic signed [rspb_pkg::RSSI_W-1:0] val_q;
	logic signed [rspb_pkg::RSSI_W-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= rspb_pkg::LVL_FLOOR;
			max_q <= rspb_pkg::LVL_FLOOR;
		end else begin
			if (shift_en) begin
				val_q <= data_in;
			end
			max_q <= (val_q > max_in) ? val_q : max_in;
		end
	end

	assign data_out = val_q;
	assign max_out  = max_q;
endmodule
`default_nettype wire

/* rtl/rspb_divider.sv */
// division of the mapping numerator by its constant through reciprocal multiplication
`default_nettype none
module rspb_divider (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              cube,
	input  wire logic [rspb_pkg::NUM_W-1:0]        num,
	output logic                                   done,
	output logic [rspb_pkg::QUOT_W-1:0]            quot
);
	localparam int PROD_W = rspb_pkg::NUM_W + rspb_pkg::RECIP_W;

	logic                          vld_s1;
	logic                          vld_s2;
	logic                          vld_s3;
	logic                          done_q;
	logic [PROD_W-1:0]             prod_s1;
	logic [rspb_pkg::QUOT_W-1:0]   qest_s2;
	logic [rspb_pkg::QUOT_W-1:0]   qest_s3;
	logic [rspb_pkg::NUM_W-1:0]    rem_s3;
	logic [rspb_pkg::QUOT_W-1:0]   quot_q;
	logic [rspb_pkg::DEN_W-1:0]    den;
	logic [rspb_pkg::RECIP_W-1:0]  recip;

	assign den   = cube ? rspb_pkg::CUBE_DEN : rspb_pkg::LIN_DEN;
	assign recip = cube ? rspb_pkg::CUBE_RECIP : rspb_pkg::LIN_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// estimate is low by at most one, the remainder compare fixes it
	always_ff @(posedge clk) begin
		prod_s1 <= {{rspb_pkg::RECIP_W{1'b0}}, num} * {{rspb_pkg::NUM_W{1'b0}}, recip};
		qest_s2 <= cube ? prod_s1[rspb_pkg::CUBE_SHIFT +: rspb_pkg::QUOT_W]
		                : prod_s1[rspb_pkg::LIN_SHIFT +: rspb_pkg::QUOT_W];
		qest_s3 <= qest_s2;
		rem_s3  <= num - ({{rspb_pkg::DEN_W{1'b0}}, qest_s2} * {{rspb_pkg::QUOT_W{1'b0}}, den});
		if (vld_s3) begin
			quot_q <= qest_s3 + {{(rspb_pkg::QUOT_W-1){1'b0}},
			                     (rem_s3 >= {{rspb_pkg::QUOT_W{1'b0}}, den})};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

/* rtl/rssi_peak_brightness_controller.sv */
// top level: history cell row, level smoothing, duty mapping and supply handling
// packet items shift the history row and record their timestamp, with no result; tick and voltage items
// run through the peak wave over the cell row, the update, the multiply states and the
// 4-stage divide to a valid result; the next item is taken once that result is loaded
// reset is asynchronous: history cells read -100, control, state and configuration registers take their reset values
// no clearing pass is needed; an item is accepted in the first cycle after reset
`default_nettype none
module rssi_peak_brightness_controller #(
	parameter int HISTORY_DEPTH = rspb_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [rspb_pkg::FUNC_W-1:0]            func,
	input  wire logic signed [rspb_pkg::RSSI_W-1:0]     rssi_dbm,
	input  wire logic [rspb_pkg::TIME_W-1:0]            timestamp_ms,
	input  wire logic [rspb_pkg::MV_W-1:0]              vin_mv,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [rspb_pkg::DUTY_W-1:0]                 duty,
	output logic                                        override_active,
	output logic                                        reduced_power,
	output logic signed [rspb_pkg::RSSI_W-1:0]          peak_rssi,
	output logic signed [rspb_pkg::RSSI_W-1:0]          level_dbm,
	input  wire logic                                   cfg_we,
	input  wire logic [rspb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [rspb_pkg::CFG_DATA_W-1:0]        cfg_data
);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	rspb_pkg::state_t state_q, state_d;

	// configuration
	logic                            map_mode_q;
	logic [15:0]                     timeout_q;
	logic [rspb_pkg::DUTY_W-1:0]     full_scale_q;
	logic [rspb_pkg::MV_W-1:0]       reduce_mv_q;
	logic [rspb_pkg::MV_W-1:0]       cutoff_mv_q;

	// state
	logic [rspb_pkg::TIME_W-1:0]     last_pkt_q;
	logic signed [rspb_pkg::LEVEL_W-1:0] level_q;
	logic [rspb_pkg::DUTY_W-1:0]     max_duty_q;
	logic                            override_q;

	// item in flight
	logic [rspb_pkg::FUNC_W-1:0]     func_q;
	logic [rspb_pkg::TIME_W-1:0]     ts_q;
	logic [rspb_pkg::MV_W-1:0]       vin_q;
	logic [CNT_W-1:0]                cnt_q;
	logic signed [rspb_pkg::RSSI_W-1:0] peak_q;
	logic [5:0]                      n_q;
	logic [rspb_pkg::DUTY_W-1:0]     span_q;
	logic [11:0]                     nsq_q;
	logic [17:0]                     ncube_q;
	logic [rspb_pkg::NUM_W-1:0]      num_q;

	// output register
	logic                            out_valid_q;
	logic [rspb_pkg::DUTY_W-1:0]     duty_q;
	logic                            override_out_q;
	logic                            reduced_q;
	logic signed [rspb_pkg::RSSI_W-1:0] peak_out_q;
	logic signed [rspb_pkg::RSSI_W-1:0] level_out_q;

	logic in_acc;
	logic out_free;
	logic out_load;
	logic shift_en;
	logic div_start;
	logic div_done;
	logic [rspb_pkg::QUOT_W-1:0] div_quot;

	logic signed [rspb_pkg::RSSI_W-1:0] data_w [0:HISTORY_DEPTH];
	logic signed [rspb_pkg::RSSI_W-1:0] max_w  [0:HISTORY_DEPTH];

	assign data_w[0] = rssi_dbm;
	assign max_w[0]  = rspb_pkg::LVL_FLOOR;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		rspb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.data_in  (data_w[i]),
			.max_in   (max_w[i]),
			.data_out (data_w[i+1]),
			.max_out  (max_w[i+1])
		);
	end

	// level update arithmetic
	logic signed [17:0] diff;
	logic [16:0]        mag;
	logic [16:0]        half;
	logic signed [17:0] lvl_recent;
	logic signed [16:0] fade_d;
	logic [21:0]        fade_prod;
	logic [21:0]        fade_sum;
	logic signed [17:0] lvl_fade;
	logic               recent;
	logic [rspb_pkg::TIME_W-1:0] gap;

	always_comb begin
		gap = ts_q - last_pkt_q;
		recent = (gap <= {16'd0, timeout_q});
		diff = $signed({{2{peak_q[7]}}, peak_q, 8'd0}) - $signed({{2{level_q[15]}}, level_q});
		mag = diff[17] ? 17'(-diff) : diff[16:0];
		half = (mag + 17'd1) >> 1;
		lvl_recent = diff[17] ? ($signed({{2{level_q[15]}}, level_q}) - $signed({1'b0, half}))
		                      : ($signed({{2{level_q[15]}}, level_q}) + $signed({1'b0, half}));
		fade_d = $signed({level_q[15], level_q}) - $signed({rspb_pkg::LVL_Q8_FLOOR[15],
		                                                     rspb_pkg::LVL_Q8_FLOOR});
		fade_prod = {6'd0, fade_d[15:0]} * rspb_pkg::FADE_NUM;
		fade_sum = fade_prod + rspb_pkg::FADE_RND;
		lvl_fade = $signed({{2{level_q[15]}}, level_q}) - $signed({4'd0, fade_sum[21:8]});
	end

	// level to duty index
	logic                                frac_nz;
	logic signed [rspb_pkg::RSSI_W-1:0]  lvl_whole;
	logic signed [rspb_pkg::RSSI_W-1:0]  lvl_clamp;
	logic signed [rspb_pkg::RSSI_W-1:0]  lvl_off;
	logic [rspb_pkg::DUTY_W-1:0]         span_d;

	always_comb begin
		frac_nz = level_q[15] && (level_q[7:0] != 8'd0);
		lvl_whole = $signed(level_q[15:8]) + $signed({7'd0, frac_nz});
		if (lvl_whole < rspb_pkg::LVL_FLOOR) begin
			lvl_clamp = rspb_pkg::LVL_FLOOR;
		end else if (lvl_whole > rspb_pkg::LVL_TOP) begin
			lvl_clamp = rspb_pkg::LVL_TOP;
		end else begin
			lvl_clamp = lvl_whole;
		end
		lvl_off = lvl_clamp - rspb_pkg::LVL_FLOOR;
		span_d = (max_duty_q > rspb_pkg::DUTY_MIN) ? (max_duty_q - rspb_pkg::DUTY_MIN) : max_duty_q;
	end

	// final duty
	logic [rspb_pkg::DUTY_W:0]   pwm;
	logic [rspb_pkg::DUTY_W-1:0] duty_res;

	always_comb begin
		pwm = {1'b0, div_quot} + {1'b0, rspb_pkg::DUTY_MIN};
		if (override_q) begin
			duty_res = rspb_pkg::DUTY_MIN;
		end else if (pwm > {1'b0, max_duty_q}) begin
			duty_res = max_duty_q;
		end else begin
			duty_res = pwm[rspb_pkg::DUTY_W-1:0];
		end
	end

	rspb_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.cube   (map_mode_q),
		.num    (num_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rspb_pkg::ST_IDLE: begin
				if (in_acc && (func == rspb_pkg::FUNC_TICK || func == rspb_pkg::FUNC_VOLT)) begin
					state_d = rspb_pkg::ST_PEAK;
				end
			end
			rspb_pkg::ST_PEAK: begin
				if (cnt_q == '0) begin
					state_d = rspb_pkg::ST_UPD;
				end
			end
			rspb_pkg::ST_UPD:    state_d = rspb_pkg::ST_MUL1;
			rspb_pkg::ST_MUL1:   state_d = rspb_pkg::ST_MUL2;
			rspb_pkg::ST_MUL2:   state_d = rspb_pkg::ST_MUL3;
			rspb_pkg::ST_MUL3:   state_d = rspb_pkg::ST_DSTART;
			rspb_pkg::ST_DSTART: state_d = rspb_pkg::ST_DWAIT;
			rspb_pkg::ST_DWAIT: begin
				if (div_done) begin
					state_d = rspb_pkg::ST_FIN;
				end
			end
			rspb_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = rspb_pkg::ST_IDLE;
				end
			end
			default: state_d = rspb_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != rspb_pkg::ST_IDLE);
		out_free  = !out_valid_q || !out_stall;
		in_acc    = in_valid && (state_q == rspb_pkg::ST_IDLE);
		shift_en  = in_acc && (func == rspb_pkg::FUNC_PACKET);
		div_start = (state_q == rspb_pkg::ST_DSTART);
		out_load  = (state_q == rspb_pkg::ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rspb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_mode_q   <= rspb_pkg::RST_MAP_MODE;
			timeout_q    <= rspb_pkg::RST_TIMEOUT;
			full_scale_q <= rspb_pkg::RST_FULL_SCALE;
			reduce_mv_q  <= rspb_pkg::RST_REDUCE_MV;
			cutoff_mv_q  <= rspb_pkg::RST_CUTOFF_MV;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rspb_pkg::REG_MAP_MODE:   map_mode_q   <= cfg_data[0];
				rspb_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data;
				rspb_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data;
				rspb_pkg::REG_REDUCE_MV:  reduce_mv_q  <= cfg_data[rspb_pkg::MV_W-1:0];
				rspb_pkg::REG_CUTOFF_MV:  cutoff_mv_q  <= cfg_data[rspb_pkg::MV_W-1:0];
				default: ;
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pkt_q <= '0;
			level_q    <= rspb_pkg::LVL_Q8_FLOOR;
			max_duty_q <= rspb_pkg::RST_FULL_SCALE;
			override_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (shift_en) begin
				last_pkt_q <= timestamp_ms;
			end
			if (in_acc) begin
				cnt_q <= CNT_W'(HISTORY_DEPTH);
			end else if (state_q == rspb_pkg::ST_PEAK && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (state_q == rspb_pkg::ST_UPD) begin
				if (func_q == rspb_pkg::FUNC_TICK) begin
					if (recent) begin
						level_q <= lvl_recent[rspb_pkg::LEVEL_W-1:0];
					end else if (fade_d > 17'sd0) begin
						level_q <= lvl_fade[rspb_pkg::LEVEL_W-1:0];
					end
				end else begin
					if (!override_q) begin
						if (vin_q < reduce_mv_q && max_duty_q == full_scale_q) begin
							max_duty_q <= full_scale_q >> 1;
						end else if (vin_q >= reduce_mv_q && max_duty_q != full_scale_q) begin
							max_duty_q <= full_scale_q;
						end
					end
					override_q <= (vin_q < cutoff_mv_q);
				end
			end
		end
	end

	// item payload and mapping datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			ts_q   <= timestamp_ms;
			vin_q  <= vin_mv;
		end
		if (state_q == rspb_pkg::ST_PEAK) begin
			peak_q <= max_w[HISTORY_DEPTH];
		end
		if (state_q == rspb_pkg::ST_MUL1) begin
			n_q    <= lvl_off[5:0];
			span_q <= span_d;
			nsq_q  <= {6'd0, lvl_off[5:0]} * {6'd0, lvl_off[5:0]};
		end
		if (state_q == rspb_pkg::ST_MUL2) begin
			ncube_q <= map_mode_q ? ({6'd0, nsq_q} * {12'd0, n_q}) : {12'd0, n_q};
		end
		if (state_q == rspb_pkg::ST_MUL3) begin
			num_q <= ({16'd0, ncube_q} * {18'd0, span_q})
			         + (map_mode_q ? rspb_pkg::CUBE_RND : rspb_pkg::LIN_RND);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			duty_q         <= duty_res;
			override_out_q <= override_q;
			reduced_q      <= (max_duty_q != full_scale_q);
			peak_out_q     <= peak_q;
			level_out_q    <= lvl_whole;
		end
	end

	assign out_valid       = out_valid_q;
	assign duty            = duty_q;
	assign override_active = override_out_q;
	assign reduced_power   = reduced_q;
	assign peak_rssi       = peak_out_q;
	assign level_dbm       = level_out_q;
endmodule
`default_nettype wire

/* rtl/rspb_checker.sv */
// port-level checks for the rssi peak brightness controller
`default_nettype none
module rspb_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic [rspb_pkg::DUTY_W-1:0]          duty,
	input wire logic                                 override_active,
	input wire logic signed [rspb_pkg::RSSI_W-1:0]   peak_rssi,
	input wire logic signed [rspb_pkg::RSSI_W-1:0]   level_dbm
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty) && $stable(level_dbm))
		else $error("stalled item changed");

	a_override_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && override_active |-> duty == rspb_pkg::DUTY_MIN)
		else $error("override item without minimum duty");

	a_peak_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_rssi >= rspb_pkg::LVL_FLOOR)
		else $error("peak below floor");

	a_level_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_dbm >= rspb_pkg::LVL_FLOOR)
		else $error("level below floor");
endmodule

bind rssi_peak_brightness_controller rspb_checker u_rspb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.duty            (duty),
	.override_active (override_active),
	.peak_rssi       (peak_rssi),
	.level_dbm       (level_dbm)
);
`default_nettype wire
